/* sv/bfpa_pkg.sv */
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants and controller/datapath interface types for the best-fit
// partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    // Default storage geometry.
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Fixed field widths of the request and result items.
    localparam int MODE_W   = 1;
    localparam int TARGET_W = 4;
    localparam int AMOUNT_W = 16;
    localparam int NUMP_W   = 5;
    localparam int PART_W   = 4;
    localparam int LEFT_W   = 16;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((TARGET_W + AMOUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PART_W + LEFT_W + 7) / 8) * 8;

    // Partition count after reset.
    localparam logic [NUMP_W-1:0] NUMP_RESET = NUMP_W'(16);

    // Request kinds carried in the slave-side tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // write a capacity from the incoming request
        logic start;       // latch an allocation request, clear the search
        logic issue;       // read the next partition and advance the index
        logic write_resp;  // update the chosen partition and load the result
    } t_bfpa_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue;  // the index being read is the last one searched
        logic count_zero;  // no partition is searched
        logic out_free;    // the result register can take a new result
    } t_bfpa_stat;

endpackage

/* sv/best_fit_partition_allocator_core.sv */
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_core
// Best-fit allocator over a table of fixed memory partitions.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel. s_axis_tuser selects the kind: a
// load request writes one partition capacity and gives no result, an
// allocation request searches the partitions for the smallest capacity that
// still holds the requested amount, lowest index on ties, and subtracts it.
// Each allocation gives one result on the m_axis channel: a flag in tuser,
// the chosen partition and the capacity left in tdata (both zero when no
// partition fits). The user must write the partition count through i_cfg_we
// and i_cfg_wdata only while the block is idle; the block does not enforce it.
// Loads may follow back to back. For an allocation request the scan reads
// one capacity per cycle from the single read port of the capacity memory,
// for each partition searched, followed by a drain step for the last
// compare and a write-back step that loads the result. With no partition
// searched the scan and the drain step are skipped.
// The next request is accepted in the cycle after the result is loaded, even
// if that result still waits in the output register. A stalled receiver holds
// the result there; a further allocation then waits in its last step.
// Reset clears all valid bits, so every capacity reads as zero, and sets the
// count to 16; there is no clearing pass, so the block takes requests right
// after reset.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_core #(
    parameter int MAX_PARTITIONS = bfpa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = bfpa_pkg::SIZE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration: partition count.
    input  logic                                  i_cfg_we,
    input  logic [bfpa_pkg::NUMP_W-1:0]           i_cfg_wdata,
    // Request channel.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: target_partition [3:0], amount [19:4], zero fill [23:20].
    input  logic [bfpa_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // tuser: mode [0].
    input  logic [bfpa_pkg::MODE_W-1:0]           s_axis_tuser,
    // Result channel.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: chosen_partition [3:0], left_over [19:4], zero fill [23:20].
    output logic [bfpa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // tuser: allocated [0].
    output logic [0:0]                            m_axis_tuser
);
    import bfpa_pkg::*;

    t_bfpa_cmd          cmd;
    t_bfpa_stat         stat;
    logic [TARGET_W-1:0] req_target;
    logic [AMOUNT_W-1:0] req_amount;
    logic                out_alloc;
    logic [PART_W-1:0]   out_part;
    logic [LEFT_W-1:0]   out_left;

    // Unpack the request payload, target in the low bits.
    assign req_target = s_axis_tdata[TARGET_W-1:0];
    assign req_amount = s_axis_tdata[TARGET_W +: AMOUNT_W];

    bfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_mode  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bfpa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_target    (req_target),
        .i_amount    (req_amount),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_alloc (out_alloc),
        .o_out_part  (out_part),
        .o_out_left  (out_left)
    );

    // Pack the result: partition in the low bits, then the capacity left.
    assign m_axis_tdata = {{(M_TDATA_W - PART_W - LEFT_W){1'b0}}, out_left, out_part};
    assign m_axis_tuser = out_alloc;

endmodule

/* sv/bfpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer for the allocator: takes requests, steps the partition scan and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bfpa_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  logic [bfpa_pkg::MODE_W-1:0]          i_req_mode,
    output logic                                 o_req_ready,
    input  bfpa_pkg::t_bfpa_stat                 i_stat,
    output bfpa_pkg::t_bfpa_cmd                  o_cmd
);
    import bfpa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_mode == MODE_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_stat.count_zero ? ST_RESP : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last partition read is compared in this cycle.
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.write_resp = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/bfpa_dp.sv */
// ----------------------------------------------------------------------------
// bfpa_dp
// Datapath of the allocator: capacity memory with per-entry valid bits,
// partition count register, best-fit compare stage and result register.
// ----------------------------------------------------------------------------
module bfpa_dp #(
    parameter int MAX_PARTITIONS = bfpa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = bfpa_pkg::SIZE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bfpa_pkg::NUMP_W-1:0]          i_cfg_wdata,
    input  logic [bfpa_pkg::TARGET_W-1:0]        i_target,
    input  logic [bfpa_pkg::AMOUNT_W-1:0]        i_amount,
    input  bfpa_pkg::t_bfpa_cmd                  i_cmd,
    output bfpa_pkg::t_bfpa_stat                 o_stat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_out_alloc,
    output logic [bfpa_pkg::PART_W-1:0]          o_out_part,
    output logic [bfpa_pkg::LEFT_W-1:0]          o_out_left
);
    import bfpa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CW    = (NUMP_W > IDX_W + 1) ? NUMP_W : IDX_W + 1;
    localparam int AW    = (AMOUNT_W > SIZE_BITS) ? AMOUNT_W : SIZE_BITS;

    // Capacity store; an entry never loaded since reset reads as zero.
    logic [SIZE_BITS-1:0] mem [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] r_vld;

    logic [NUMP_W-1:0]    r_num_part;
    logic [AMOUNT_W-1:0]  r_amount;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_en;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_cap;
    logic                 r_out_valid;
    logic                 r_out_alloc;
    logic [PART_W-1:0]    r_out_part;
    logic [LEFT_W-1:0]    r_out_left;

    logic [CW-1:0]        eff_count;
    logic [SIZE_BITS-1:0] cap;
    logic                 fits;
    logic                 better;
    logic                 load_ok;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [SIZE_BITS-1:0] new_cap;

    // The search covers the smaller of the programmed count and the store depth.
    always_comb begin
        if (CW'(r_num_part) > CW'(MAX_PARTITIONS)) begin
            eff_count = CW'(MAX_PARTITIONS);
        end else begin
            eff_count = CW'(r_num_part);
        end
    end

    assign o_stat.count_zero = (eff_count == '0);
    assign o_stat.last_issue = ((CW'(r_rd_idx) + CW'(1)) == eff_count);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign cap     = r_rd_vld ? r_rd_data : '0;
    assign fits    = (AW'(r_amount) <= AW'(cap));
    assign better  = !r_found || (cap < r_best_cap);
    assign new_cap = r_best_cap - SIZE_BITS'(r_amount);
    assign load_ok = (32'(i_target) < 32'(MAX_PARTITIONS));

    always_comb begin
        if (i_cmd.load) begin
            wr_en   = load_ok;
            wr_addr = IDX_W'(i_target);
            wr_data = SIZE_BITS'(i_amount);
        end else begin
            wr_en   = i_cmd.write_resp && r_found;
            wr_addr = r_best_idx;
            wr_data = new_cap;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_num_part  <= NUMP_RESET;
            r_cmp_en    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_num_part <= i_cfg_wdata;
            end
            r_cmp_en <= i_cmd.issue;
            if (i_cmd.start) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
                if (r_cmp_en && fits && better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.write_resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_vld[r_rd_idx];
        r_cmp_idx <= r_rd_idx;
        if (i_cmd.start) begin
            r_amount <= i_amount;
        end
        if (r_cmp_en && fits && better) begin
            r_best_idx <= r_cmp_idx;
            r_best_cap <= cap;
        end
        if (i_cmd.write_resp) begin
            r_out_alloc <= r_found;
            r_out_part  <= r_found ? PART_W'(r_best_idx) : '0;
            r_out_left  <= r_found ? LEFT_W'(new_cap) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_alloc = r_out_alloc;
    assign o_out_part  = r_out_part;
    assign o_out_left  = r_out_left;

endmodule
